// ===== sv/pima_pkg.sv =====
`timescale 1ns / 1ps
// Package for the projective inverse-map address block.
// Shared types and constants; no dependencies.
package pima_pkg;
    localparam int MAX_DIM = 4096;
    localparam int DIM_W = 13;
    localparam int CRD_W = 12;
    localparam int SUM_W = 46;
    localparam int QB = 13;
    localparam int IDX_W = 24;
    localparam logic [2:0] REG_PAIR_A = 3'd0;
    localparam logic [2:0] REG_PAIR_B = 3'd1;
    localparam logic [2:0] REG_PAIR_C = 3'd2;
    localparam logic [2:0] REG_PAIR_D = 3'd3;
    localparam logic [2:0] REG_H22 = 3'd4;
    localparam logic [2:0] REG_WIDTH = 3'd5;
    localparam logic [2:0] REG_HEIGHT = 3'd6;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [SUM_W-1:0] mag_t;
endpackage

// ===== sv/projective_inverse_map_address_top.sv =====
`timescale 1ns / 1ps
// Top level: maps each output pixel through a 3x3 inverse homography to a source address.
// Depends on pima_pkg.
// One request per clock unless the output stalls: two product/sum stages, a sign and quotient-size
// stage, 13 restoring-division stages (x and y in parallel), a range check with the index multiply,
// then output. The user must write configuration only while no request is in flight; the block does not enforce it.
module projective_inverse_map_address_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // out_col[11:0], out_row[23:12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // src_x[11:0], src_y[23:12], src_index[47:24]
    output logic        m_tuser,   // in_range
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    localparam int NS = 3 + pima_pkg::QB + 2;
    localparam int SW = pima_pkg::SUM_W;
    localparam int QB = pima_pkg::QB;

    logic [63:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic [31:0] h22_reg;
    logic [12:0] wd_reg, ht_reg;
    logic [12:0] wd_eff, ht_eff;
    logic        adv;
    logic [NS-1:0] v_reg;

    assign cfg_ready = 1'b1;
    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign m_tvalid = v_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pa_reg <= 64'd4503599627370496;
            pb_reg <= '0;
            pc_reg <= 64'd4503599627370496;
            pd_reg <= '0;
            h22_reg <= 32'd1048576;
            wd_reg <= 13'd4096;
            ht_reg <= 13'd4096;
        end else if (cfg_valid) begin
            case (cfg_index)
                pima_pkg::REG_PAIR_A: pa_reg <= cfg_data;
                pima_pkg::REG_PAIR_B: pb_reg <= cfg_data;
                pima_pkg::REG_PAIR_C: pc_reg <= cfg_data;
                pima_pkg::REG_PAIR_D: pd_reg <= cfg_data;
                pima_pkg::REG_H22: h22_reg <= cfg_data[31:0];
                pima_pkg::REG_WIDTH: wd_reg <= cfg_data[12:0];
                pima_pkg::REG_HEIGHT: ht_reg <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    assign wd_eff = (wd_reg > 13'(pima_pkg::MAX_DIM)) ? 13'(pima_pkg::MAX_DIM) : wd_reg;
    assign ht_eff = (ht_reg > 13'(pima_pkg::MAX_DIM)) ? 13'(pima_pkg::MAX_DIM) : ht_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg <= '0;
        else if (adv) v_reg <= {v_reg[NS-2:0], s_tvalid};
    end

    // stage 1: six products
    logic signed [44:0] p_reg [6];
    logic signed [31:0] c0_reg, c1_reg, c2_reg;
    logic signed [12:0] col_s, row_s;
    assign col_s = $signed({1'b0, s_tdata[11:0]});
    assign row_s = $signed({1'b0, s_tdata[23:12]});
    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg[0] <= $signed(pa_reg[63:32]) * col_s;
            p_reg[1] <= $signed(pa_reg[31:0]) * row_s;
            p_reg[2] <= $signed(pb_reg[31:0]) * col_s;
            p_reg[3] <= $signed(pc_reg[63:32]) * row_s;
            p_reg[4] <= $signed(pd_reg[63:32]) * col_s;
            p_reg[5] <= $signed(pd_reg[31:0]) * row_s;
            c0_reg <= $signed(pb_reg[63:32]);
            c1_reg <= $signed(pc_reg[31:0]);
            c2_reg <= $signed(h22_reg);
        end
    end

    // stage 2: sums
    pima_pkg::sum_t x_reg, y_reg, w_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg <= SW'(p_reg[0]) + SW'(p_reg[1]) + SW'(c0_reg);
            y_reg <= SW'(p_reg[2]) + SW'(p_reg[3]) + SW'(c1_reg);
            w_reg <= SW'(p_reg[4]) + SW'(p_reg[5]) + SW'(c2_reg);
        end
    end

    // stage 3: sign fold; quotients must fit in QB bits
    pima_pkg::sum_t xn, yn, wn;
    logic [SW+QB-1:0] wtop;
    logic ok;
    always_comb begin
        xn = (w_reg < 0) ? -x_reg : x_reg;
        yn = (w_reg < 0) ? -y_reg : y_reg;
        wn = (w_reg < 0) ? -w_reg : w_reg;
        wtop = (SW+QB)'(pima_pkg::mag_t'(wn)) << QB;
        ok = (wn > 0) && (xn >= 0) && (yn >= 0)
            && ((SW+QB)'(pima_pkg::mag_t'(xn)) < wtop)
            && ((SW+QB)'(pima_pkg::mag_t'(yn)) < wtop);
    end

    pima_pkg::mag_t dx_reg [QB+1], dy_reg [QB+1], dw_reg [QB+1];
    logic [QB-1:0]  qx_reg [QB+1], qy_reg [QB+1];
    logic           ok_reg [QB+1];
    logic [12:0]    dwd_reg [QB+1];
    logic [12:0]    dht_reg [QB+1];
    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg[0] <= ok ? pima_pkg::mag_t'(xn) : '0;
            dy_reg[0] <= ok ? pima_pkg::mag_t'(yn) : '0;
            dw_reg[0] <= ok ? pima_pkg::mag_t'(wn) : SW'(1);
            qx_reg[0] <= '0;
            qy_reg[0] <= '0;
            ok_reg[0] <= ok;
            dwd_reg[0] <= wd_eff;
            dht_reg[0] <= ht_eff;
        end
    end

    // restoring division, one quotient bit per stage, MSB first
    for (genvar i = 0; i < QB; i++) begin : g_div
        localparam int SH = QB - 1 - i;
        logic [SW+QB-1:0] tw;
        logic bx, by;
        assign tw = (SW+QB)'(dw_reg[i]) << SH;
        assign bx = (SW+QB)'(dx_reg[i]) >= tw;
        assign by = (SW+QB)'(dy_reg[i]) >= tw;
        always_ff @(posedge aclk) begin
            if (adv) begin
                dx_reg[i+1] <= bx ? SW'((SW+QB)'(dx_reg[i]) - tw) : dx_reg[i];
                dy_reg[i+1] <= by ? SW'((SW+QB)'(dy_reg[i]) - tw) : dy_reg[i];
                dw_reg[i+1] <= dw_reg[i];
                qx_reg[i+1] <= {qx_reg[i][QB-2:0], bx};
                qy_reg[i+1] <= {qy_reg[i][QB-2:0], by};
                ok_reg[i+1] <= ok_reg[i];
                dwd_reg[i+1] <= dwd_reg[i];
                dht_reg[i+1] <= dht_reg[i];
            end
        end
    end

    // range check and index multiply, then output
    logic [11:0] sx_reg, sy_reg, ox_reg, oy_reg;
    logic [25:0] im_reg;
    logic [23:0] oi_reg;
    logic        ok2_reg, oo_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            sx_reg <= qx_reg[QB][11:0];
            sy_reg <= qy_reg[QB][11:0];
            im_reg <= qy_reg[QB][11:0] * dwd_reg[QB];
            ok2_reg <= ok_reg[QB] && (qx_reg[QB] < dwd_reg[QB])
                && (qy_reg[QB] < dht_reg[QB]);
            ox_reg <= ok2_reg ? sx_reg : '0;
            oy_reg <= ok2_reg ? sy_reg : '0;
            oi_reg <= ok2_reg ? 24'(im_reg + 26'(sx_reg)) : '0;
            oo_reg <= ok2_reg;
        end
    end

    assign m_tdata = {oi_reg, oy_reg, ox_reg};
    assign m_tuser = oo_reg;
endmodule

// ===== sv/pima_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the top level, with its bind statement.
// Depends on projective_inverse_map_address_top.
module pima_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0) else $error("black pixel not zero");
    a_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[47:24] >= {12'd0, m_tdata[11:0]})
        else $error("index below column");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");
endmodule

bind projective_inverse_map_address_top pima_checker u_pima_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
);
